// ===== hw/rtl/dcag_pkg.sv =====
// ----------------------------------------------------------------------------
// dcag_pkg
// Shared types, codes and helpers of the DMA channel address generator.
// ----------------------------------------------------------------------------
package dcag_pkg;

  localparam int CHANNELS = 4;
  localparam int COUNT_W  = 16;

  // control word fields
  localparam int CTL_DMODE_LSB  = 21;
  localparam int CTL_SMODE_LSB  = 23;
  localparam int CTL_WORD_BIT   = 26;
  localparam int CTL_TIMING_LSB = 28;
  localparam int CTL_ENABLE_BIT = 31;

  localparam logic [1:0] TIMING_NOW = 2'd0;

  typedef enum logic [1:0] {
    FN_PROG = 2'd0,
    FN_STOP = 2'd1,
    FN_STEP = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_MOVED    = 2'd1,
    ST_ACCEPTED = 2'd2,
    ST_BAD_SRC  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_INC    = 2'd0,
    MODE_DEC    = 2'd1,
    MODE_FIXED  = 2'd2,
    MODE_RELOAD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    UPD_NONE = 2'd0,
    UPD_PROG = 2'd1,
    UPD_STOP = 2'd2,
    UPD_STEP = 2'd3
  } upd_kind_t;

  typedef struct packed {
    logic [31:0]        src;
    logic [31:0]        dst;
    logic [31:0]        dst_start;
    logic [COUNT_W-1:0] remaining;
    mode_t              dst_mode;
    mode_t              src_mode;
    logic               word;
    logic [1:0]         timing;
    logic               enable;
  } chan_state_t;

  typedef struct packed {
    upd_kind_t          kind;
    logic [1:0]         ch;
    logic [31:0]        src;
    logic [31:0]        dst;
    logic [COUNT_W-1:0] remaining;
    mode_t              dst_mode;
    mode_t              src_mode;
    logic               word;
    logic [1:0]         timing;
    logic               enable;
  } chan_upd_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  ch;
    logic [31:0] src;
    logic [31:0] dst;
    logic        word;
    logic        last;
  } result_t;

  // signed address step for one unit
  function automatic logic [31:0] step_amount(mode_t mode, logic word);
    logic [31:0] size;
    size = word ? 32'd4 : 32'd2;
    case (mode)
      MODE_DEC:   step_amount = 32'd0 - size;
      MODE_FIXED: step_amount = 32'd0;
      default:    step_amount = size;
    endcase
  endfunction

endpackage

// ===== hw/rtl/dcag_chan_file.sv =====
// ----------------------------------------------------------------------------
// dcag_chan_file
// Per-channel address, count and control registers with one update port.
// ----------------------------------------------------------------------------
module dcag_chan_file
  import dcag_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  chan_upd_t   upd,
  output chan_state_t chans [CHANNELS]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        chans[k].enable <= 1'b0;
        chans[k].timing <= TIMING_NOW;
      end
    end else begin
      case (upd.kind)
        UPD_PROG: begin
          chans[upd.ch].src       <= upd.src;
          chans[upd.ch].dst       <= upd.dst;
          chans[upd.ch].dst_start <= upd.dst;
          chans[upd.ch].remaining <= upd.remaining;
          chans[upd.ch].dst_mode  <= upd.dst_mode;
          chans[upd.ch].src_mode  <= upd.src_mode;
          chans[upd.ch].word      <= upd.word;
          chans[upd.ch].timing    <= upd.timing;
          chans[upd.ch].enable    <= upd.enable;
        end
        UPD_STOP: begin
          chans[upd.ch].timing <= TIMING_NOW;
          chans[upd.ch].enable <= 1'b0;
        end
        UPD_STEP: begin
          chans[upd.ch].src       <= upd.src;
          chans[upd.ch].dst       <= upd.dst;
          chans[upd.ch].remaining <= upd.remaining;
          chans[upd.ch].enable    <= upd.enable;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    upd.kind == UPD_STOP |=>
      !chans[$past(upd.ch)].enable && chans[$past(upd.ch)].timing == TIMING_NOW)
    else $error("stop left channel enabled");

  a_last_disables: assert property (@(posedge clk) disable iff (rst)
    upd.kind == UPD_STEP && upd.remaining == '0 |=> !chans[$past(upd.ch)].enable)
    else $error("channel still enabled after last unit");

  a_prog_start: assert property (@(posedge clk) disable iff (rst)
    upd.kind == UPD_PROG |=> chans[$past(upd.ch)].dst_start == chans[$past(upd.ch)].dst)
    else $error("program did not latch start destination");
`endif

endmodule

// ===== hw/rtl/dcag_exec.sv =====
// ----------------------------------------------------------------------------
// dcag_exec
// Decodes one request against the channel registers: builds the result
// and the register update.
// ----------------------------------------------------------------------------
module dcag_exec
  import dcag_pkg::*;
(
  input  logic [1:0]  func,
  input  logic [1:0]  channel,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [31:0] control_word,
  input  chan_state_t chans [CHANNELS],
  output result_t     res,
  output chan_upd_t   upd
);

  logic [CHANNELS-1:0] active;
  logic                sel_found;
  logic [1:0]          sel;
  chan_state_t         cur;
  logic                in_range;
  logic                ctl_en;
  logic [1:0]          ctl_tm;
  mode_t               ctl_sm;
  logic [COUNT_W-1:0]  rem_next;

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      active[k] = chans[k].enable && chans[k].timing == TIMING_NOW &&
                  chans[k].remaining != '0;
    end
  end

  // lowest active channel wins
  always_comb begin
    sel_found = 1'b0;
    sel       = 2'd0;
    for (int k = CHANNELS - 1; k >= 0; k--) begin
      if (active[k]) begin
        sel_found = 1'b1;
        sel       = 2'(k);
      end
    end
  end

  assign cur      = chans[sel];
  assign rem_next = cur.remaining - COUNT_W'(1);
  assign in_range = 32'(channel) < 32'(CHANNELS);
  assign ctl_en   = control_word[CTL_ENABLE_BIT];
  assign ctl_tm   = control_word[CTL_TIMING_LSB +: 2];
  assign ctl_sm   = mode_t'(control_word[CTL_SMODE_LSB +: 2]);

  always_comb begin
    res.status = ST_IDLE;
    res.ch     = channel;
    res.src    = '0;
    res.dst    = '0;
    res.word   = 1'b0;
    res.last   = 1'b0;

    upd.kind      = UPD_NONE;
    upd.ch        = channel;
    upd.src       = src_addr;
    upd.dst       = dst_addr;
    upd.remaining = control_word[COUNT_W-1:0];
    upd.dst_mode  = mode_t'(control_word[CTL_DMODE_LSB +: 2]);
    upd.src_mode  = ctl_sm;
    upd.word      = control_word[CTL_WORD_BIT];
    upd.timing    = ctl_tm;
    upd.enable    = ctl_en;

    case (func_t'(func))
      FN_PROG: begin
        if (in_range) begin
          upd.kind = UPD_PROG;
          if (ctl_en && ctl_tm == TIMING_NOW && ctl_sm == MODE_RELOAD) begin
            upd.enable = 1'b0;
            res.status = ST_BAD_SRC;
          end else begin
            res.status = ST_ACCEPTED;
          end
        end
      end
      FN_STOP: begin
        if (in_range) begin
          upd.kind   = UPD_STOP;
          res.status = ST_ACCEPTED;
        end
      end
      FN_STEP: begin
        if (sel_found) begin
          res.status = ST_MOVED;
          res.ch     = sel;
          res.src    = cur.src;
          res.dst    = cur.dst;
          res.word   = cur.word;
          res.last   = cur.remaining == COUNT_W'(1);

          upd.kind      = UPD_STEP;
          upd.ch        = sel;
          upd.src       = (cur.src_mode == MODE_RELOAD) ? cur.src :
                          cur.src + step_amount(cur.src_mode, cur.word);
          upd.dst       = cur.dst + step_amount(cur.dst_mode, cur.word);
          upd.remaining = rem_next;
          upd.enable    = cur.enable;
          if (rem_next == '0) begin
            upd.enable = 1'b0;
            if (cur.dst_mode == MODE_RELOAD) begin
              upd.dst = cur.dst_start;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/dma_channel_address_generator_core.sv =====
// ----------------------------------------------------------------------------
// dma_channel_address_generator_core
// Four-channel DMA address generator: program, stop and step requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries a request: func selects
//   program, stop or step; channel and the address/control fields are
//   used by program. Every request yields exactly one result on the
//   output channel (out_valid/out_stall): a status code and, for a step
//   that moved a unit, the channel, source and destination addresses,
//   unit size and last-unit flag (all but the channel zero otherwise).
//   A request passes the request register, then the result register.
//   One request per cycle is sustained while out_stall is low; the
//   channel registers are read and updated in the single pass between
//   the two registers, so back-to-back steps see each other's updates.
//   When the receiver stalls, the result register holds; the request
//   register still takes one more request, then in_stall rises.
//   Reset clears the request and result valids and disables all
//   channels; channel addresses and counts are loaded by program.
// ----------------------------------------------------------------------------
module dma_channel_address_generator_core
  import dcag_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [1:0]  channel,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [31:0] control_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  unit_channel,
  output logic [31:0] unit_src,
  output logic [31:0] unit_dst,
  output logic        unit_is_word,
  output logic        unit_last
);

  logic        req_valid;
  logic [1:0]  req_func;
  logic [1:0]  req_channel;
  logic [31:0] req_src;
  logic [31:0] req_dst;
  logic [31:0] req_ctl;

  logic        res_valid;
  result_t     res;
  result_t     exec_res;
  chan_upd_t   exec_upd;
  chan_upd_t   upd;
  chan_state_t chans [CHANNELS];

  logic advance;
  logic accept;

  assign advance  = req_valid && (!res_valid || !out_stall);
  assign in_stall = req_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        req_valid <= 1'b1;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (!out_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func    <= func;
      req_channel <= channel;
      req_src     <= src_addr;
      req_dst     <= dst_addr;
      req_ctl     <= control_word;
    end
    if (advance) begin
      res <= exec_res;
    end
  end

  dcag_exec u_exec (
    .func         (req_func),
    .channel      (req_channel),
    .src_addr     (req_src),
    .dst_addr     (req_dst),
    .control_word (req_ctl),
    .chans        (chans),
    .res          (exec_res),
    .upd          (exec_upd)
  );

  // channel registers change only when the request retires
  always_comb begin
    upd = exec_upd;
    if (!advance) begin
      upd.kind = UPD_NONE;
    end
  end

  dcag_chan_file u_chan_file (
    .clk   (clk),
    .rst   (rst),
    .upd   (upd),
    .chans (chans)
  );

  assign out_valid    = res_valid;
  assign status       = res.status;
  assign unit_channel = res.ch;
  assign unit_src     = res.src;
  assign unit_dst     = res.dst;
  assign unit_is_word = res.word;
  assign unit_last    = res.last;

`ifndef SYNTHESIS
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.status != ST_MOVED |->
      unit_src == '0 && unit_dst == '0 && !unit_is_word && !unit_last)
    else $error("unit fields set on a non-move result");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("retired request produced no result");

  a_held_request: assert property (@(posedge clk) disable iff (rst)
    req_valid && !advance |=>
      req_valid && $stable(req_func) && $stable(req_channel) && $stable(req_ctl))
    else $error("held request was lost or changed");
`endif

endmodule
